/* hdl/lci_pkg.sv */
// ----------------------------------------------------------------------------
// lci_pkg: shared types and constants of the line command interpreter
// Holds the command codes, control characters, line depth and keyword table.
// ----------------------------------------------------------------------------
package lci_pkg;

  // line buffer depth, one entry is held back so a full line keeps LineDepth-1 bytes
  localparam int LineDepth = 32;
  localparam int FillW     = $clog2(LineDepth);
  localparam int LineLenW  = 8;
  localparam int CountW    = 32;

  // command result codes
  typedef enum logic [2:0] {
    CmdNone    = 3'd0,
    CmdLedOn   = 3'd1,
    CmdLedOff  = 3'd2,
    CmdToggle  = 3'd3,
    CmdStatus  = 3'd4,
    CmdHelp    = 3'd5,
    CmdUnknown = 3'd6
  } cmd_code_e;

  // control characters
  localparam logic [7:0] ChrCr  = 8'h0D;
  localparam logic [7:0] ChrLf  = 8'h0A;
  localparam logic [7:0] ChrBs  = 8'h08;
  localparam logic [7:0] ChrDel = 8'h7F;
  localparam logic [7:0] ChrNul = 8'h00;

  // keyword table, text right aligned: first character in the highest used byte
  localparam int KwCount  = 5;
  localparam int KwMaxLen = 10;
  localparam int HeadLen  = KwMaxLen + 1;

  localparam logic [8*KwMaxLen-1:0] KwText [KwCount] = '{
    80'("LED ON"), 80'("LED OFF"), 80'("LED TOGGLE"), 80'("STATUS"), 80'("HELP")
  };
  localparam int KwLen [KwCount] = '{6, 7, 10, 6, 4};
  localparam cmd_code_e KwCode [KwCount] = '{
    CmdLedOn, CmdLedOff, CmdToggle, CmdStatus, CmdHelp
  };

  // result item layout, lowest bit first
  localparam int OutBits  = 3 + 1 + LineLenW + 2 * CountW;
  localparam int OutDataW = ((OutBits + 7) / 8) * 8;

endpackage

/* hdl/lci_classify.sv */
// ----------------------------------------------------------------------------
// lci_classify: keyword matcher
// Compares the head of the held line against all keywords in parallel.
// ----------------------------------------------------------------------------
module lci_classify import lci_pkg::*; (
  input  logic [HeadLen-1:0][7:0] head_i,   // first bytes of the line buffer
  input  logic [FillW-1:0]        fill_i,   // bytes held
  output cmd_code_e               code_o
);

  logic [KwCount-1:0] hit;

  // per keyword: length fits, text matches, and the text ends at fill or a zero byte
  always_comb begin
    int pos;
    int fill_int;
    pos      = 0;
    fill_int = int'(fill_i);
    for (int k = 0; k < KwCount; k++) begin
      hit[k] = (fill_int >= KwLen[k]);
      for (int i = 0; i < KwMaxLen; i++) begin
        pos = (i < KwLen[k]) ? (KwLen[k] - 1 - i) : 0;
        if (i < KwLen[k]) begin
          if (head_i[i] != KwText[k][8*pos +: 8]) begin
            hit[k] = 1'b0;
          end
        end
      end
      if ((fill_int != KwLen[k]) && (head_i[KwLen[k]] != ChrNul)) begin
        hit[k] = 1'b0;
      end
    end
  end

  // pick the code, an empty text gives no command
  always_comb begin
    code_o = CmdUnknown;
    for (int k = 0; k < KwCount; k++) begin
      if (hit[k]) begin
        code_o = KwCode[k];
      end
    end
    if ((fill_i == '0) || (head_i[0] == ChrNul)) begin
      code_o = CmdNone;
    end
  end

endmodule

/* hdl/line_command_interpreter.sv */
// ----------------------------------------------------------------------------
// line_command_interpreter: serial line command interpreter
// Collects received bytes into a line, decodes LED ON / LED OFF / LED TOGGLE /
// STATUS / HELP on CR or LF, and reports LED state, line length and counters.
//
// channel  | dir | bits | content
// s_axis   | in  |   8  | rx_byte
// m_axis   | out |  80  | cmd_code, led_state, line_length, rx_total, command_total
//
// One item per cycle sustained while the result side accepts; an item is held in the
// input register and then processed into the result register.
// All keyword compares run in parallel on the register-held line buffer.
// Reset clears the line, the LED bit and both counters; buffer bytes are not cleared.
// A stalled result holds the input register; the input side stalls only when both fill.
// ----------------------------------------------------------------------------
module line_command_interpreter import lci_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [2:0] cmd_code, [3] led_state,
                                              // [11:4] line_length, [43:12] rx_total,
                                              // [75:44] command_total, rest zero
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             out_valid_q;
  logic [OutBits-1:0] out_data_q;
  logic [OutBits-1:0] out_data_d;

  logic [7:0]       line_q [LineDepth];
  logic [FillW-1:0] fill_q, fill_d;
  logic             led_q, led_d;
  logic [CountW-1:0] rx_cnt_q, rx_cnt_d;
  logic [CountW-1:0] cmd_cnt_q, cmd_cnt_d;

  logic                    advance;
  logic                    store_en;
  logic [HeadLen-1:0][7:0] head;
  cmd_code_e               line_code;
  cmd_code_e               code;

  // handshake: process when a byte is held and the result slot is free
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // head of the line for the matcher
  always_comb begin
    for (int i = 0; i < HeadLen; i++) begin
      head[i] = line_q[i];
    end
  end

  lci_classify u_classify (
    .head_i (head),
    .fill_i (fill_q),
    .code_o (line_code)
  );

  // next state for one byte
  always_comb begin
    code      = CmdNone;
    fill_d    = fill_q;
    led_d     = led_q;
    cmd_cnt_d = cmd_cnt_q;
    store_en  = 1'b0;
    rx_cnt_d  = rx_cnt_q + 1'b1;
    if ((in_byte_q == ChrCr) || (in_byte_q == ChrLf)) begin
      if (fill_q != '0) begin
        code   = line_code;
        fill_d = '0;
        case (line_code)
          CmdLedOn:  led_d = 1'b1;
          CmdLedOff: led_d = 1'b0;
          CmdToggle: led_d = !led_q;
          default:   led_d = led_q;
        endcase
        if (line_code != CmdNone) begin
          cmd_cnt_d = cmd_cnt_q + 1'b1;
        end
      end
    end else if ((in_byte_q == ChrBs) || (in_byte_q == ChrDel)) begin
      if (fill_q != '0) begin
        fill_d = fill_q - 1'b1;
      end
    end else if (fill_q != FillW'(LineDepth - 1)) begin
      store_en = 1'b1;
      fill_d   = fill_q + 1'b1;
    end
    out_data_d = {cmd_cnt_d, rx_cnt_d, LineLenW'(fill_d), led_d, code};
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      led_q     <= 1'b0;
      rx_cnt_q  <= '0;
      cmd_cnt_q <= '0;
    end else if (advance) begin
      fill_q    <= fill_d;
      led_q     <= led_d;
      rx_cnt_q  <= rx_cnt_d;
      cmd_cnt_q <= cmd_cnt_d;
    end
  end

  // line buffer write
  always_ff @(posedge clk_i) begin
    if (advance && store_en) begin
      line_q[fill_q] <= in_byte_q;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule
